>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with a synchronous reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication
`define AST_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/sm83_dec_pkg.sv
// ---------------------------------------------------------------------------
// sm83_dec_pkg
// Class codes, result record and immediate length table of the decoder.
// ---------------------------------------------------------------------------
package sm83_dec_pkg;

  localparam int unsigned OpWidth  = 8;
  localparam int unsigned InWidth  = 2 * OpWidth;
  localparam int unsigned OutWidth = 40;   // 33 field bits, padded to bytes
  localparam int unsigned UserWidth = 2;

  typedef logic [5:0] op_class_t;

  localparam op_class_t CLS_NOP        = 6'd0;
  localparam op_class_t CLS_LD_A16_SP  = 6'd1;
  localparam op_class_t CLS_STOP       = 6'd2;
  localparam op_class_t CLS_JR         = 6'd3;
  localparam op_class_t CLS_JR_CC      = 6'd4;
  localparam op_class_t CLS_LD_RP_D16  = 6'd5;
  localparam op_class_t CLS_ADD_HL_RP  = 6'd6;
  localparam op_class_t CLS_LD_RPIND_A = 6'd7;
  localparam op_class_t CLS_LDI_HL_A   = 6'd8;
  localparam op_class_t CLS_LDD_HL_A   = 6'd9;
  localparam op_class_t CLS_LD_A_RPIND = 6'd10;
  localparam op_class_t CLS_LDI_A_HL   = 6'd11;
  localparam op_class_t CLS_LDD_A_HL   = 6'd12;
  localparam op_class_t CLS_INC_RP     = 6'd13;
  localparam op_class_t CLS_DEC_RP     = 6'd14;
  localparam op_class_t CLS_INC_R      = 6'd15;
  localparam op_class_t CLS_DEC_R      = 6'd16;
  localparam op_class_t CLS_LD_R_D8    = 6'd17;
  localparam op_class_t CLS_RLCA       = 6'd18;
  localparam op_class_t CLS_LD_R_R     = 6'd26;
  localparam op_class_t CLS_ALU_A_R    = 6'd27;
  localparam op_class_t CLS_LDH_A8_A   = 6'd28;
  localparam op_class_t CLS_ADD_SP_E8  = 6'd29;
  localparam op_class_t CLS_LDH_A_A8   = 6'd30;
  localparam op_class_t CLS_LDHL_SP_E8 = 6'd31;
  localparam op_class_t CLS_RET_CC     = 6'd32;
  localparam op_class_t CLS_POP        = 6'd33;
  localparam op_class_t CLS_RET        = 6'd34;
  localparam op_class_t CLS_LD_C_A     = 6'd38;
  localparam op_class_t CLS_LD_A16_A   = 6'd39;
  localparam op_class_t CLS_LD_A_C     = 6'd40;
  localparam op_class_t CLS_LD_A_A16   = 6'd41;
  localparam op_class_t CLS_JP_CC      = 6'd42;
  localparam op_class_t CLS_JP         = 6'd43;
  localparam op_class_t CLS_DI         = 6'd44;
  localparam op_class_t CLS_EI         = 6'd45;
  localparam op_class_t CLS_CALL_CC    = 6'd46;
  localparam op_class_t CLS_PUSH       = 6'd47;
  localparam op_class_t CLS_CALL       = 6'd48;
  localparam op_class_t CLS_ALU_A_D8   = 6'd49;
  localparam op_class_t CLS_RST        = 6'd50;
  localparam op_class_t CLS_CB_ROT     = 6'd51;
  localparam op_class_t CLS_CB_BIT     = 6'd52;
  localparam op_class_t CLS_CB_RES     = 6'd53;
  localparam op_class_t CLS_CB_SET     = 6'd54;
  localparam op_class_t CLS_INVALID    = 6'd55;

  typedef struct packed {
    logic       valid_res;
    logic       is_prefixed;
    logic [1:0] imm_bytes;
    logic [5:0] restart_target;
    logic [2:0] bit_index;
    logic [2:0] rotate_select;
    logic [2:0] alu_select;
    logic [1:0] condition;
    logic [1:0] reg_pair;
    logic [2:0] src_reg;
    logic [2:0] dest_reg;
    op_class_t  op_class;
  } dec_result_t;

  function automatic logic [1:0] imm_of_class(input op_class_t cls);
    logic [1:0] n;
    case (cls) inside
      CLS_LD_A16_SP, CLS_LD_RP_D16, CLS_LD_A16_A, CLS_LD_A_A16,
      CLS_JP_CC, CLS_JP, CLS_CALL_CC, CLS_CALL:               n = 2'd2;
      CLS_STOP, CLS_JR, CLS_JR_CC, CLS_LD_R_D8, CLS_LDH_A8_A,
      CLS_ADD_SP_E8, CLS_LDH_A_A8, CLS_LDHL_SP_E8, CLS_ALU_A_D8: n = 2'd1;
      default:                                                 n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/sm83_opcode_decoder_core.sv
// ---------------------------------------------------------------------------
// sm83_opcode_decoder_core
// Game Boy CPU opcode decoder with stream ports.
// ---------------------------------------------------------------------------
// Decodes one opcode (plus the following byte for the CB page) per clock.
// A transfer is taken every cycle while the output side keeps up. A result
// passes through the input register, the decode logic and then the result
// register. Either register holds while the output stalls, so the input keeps
// flowing until both are full.
`include "assert_macros.svh"

module sm83_opcode_decoder_core
  import sm83_dec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [InWidth-1:0]   s_tdata,   // opcode[7:0], next_byte[15:8]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutWidth-1:0]  m_tdata,   // op_class[5:0], dest_reg[8:6],
                                          // src_reg[11:9], reg_pair[13:12],
                                          // condition[15:14], alu_select[18:16],
                                          // rotate_select[21:19],
                                          // bit_index[24:22],
                                          // restart_target[30:25],
                                          // imm_bytes[32:31], zeros above
  output logic [UserWidth-1:0] m_tuser    // is_prefixed[0], valid_res[1]
);

  localparam int unsigned ResWidth = $bits(dec_result_t);

  logic                in_valid, in_ready;
  logic [InWidth-1:0]  in_data;
  dec_result_t         dec;
  logic [ResWidth-1:0] res_data;
  dec_result_t         res;

  sm83_dec_pipe #(.Width(InWidth)) u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (in_valid),
    .out_ready (in_ready),
    .out_data  (in_data)
  );

  sm83_dec_decode u_dec (
    .opcode    (in_data[OpWidth-1:0]),
    .next_byte (in_data[InWidth-1:OpWidth]),
    .result    (dec)
  );

  sm83_dec_pipe #(.Width(ResWidth)) u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (dec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_data)
  );

  assign res     = dec_result_t'(res_data);
  assign m_tdata = {{(OutWidth - ResWidth + UserWidth){1'b0}},
                    res_data[ResWidth-UserWidth-1:0]};
  assign m_tuser = {res.valid_res, res.is_prefixed};

  `AST_IMPLY(a_invalid_zero, clk, rst, m_tvalid && !res.valid_res,
             res.op_class == CLS_INVALID && res_data[ResWidth-1:6] == '0)
  `AST_IMPLY(a_prefix_no_imm, clk, rst, m_tvalid && res.is_prefixed,
             res.valid_res && res.imm_bytes == 2'd0)
  `AST_IMPLY(a_full_blocks_input, clk, rst, in_valid && m_tvalid && !m_tready,
             !s_tready)

endmodule

>>> rtl/sm83_dec_pipe.sv
// ---------------------------------------------------------------------------
// sm83_dec_pipe
// One pipeline register with valid/ready flow control.
// ---------------------------------------------------------------------------
module sm83_dec_pipe #(
  parameter int unsigned Width = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Width-1:0] out_data
);

  logic             valid;
  logic [Width-1:0] data;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

>>> rtl/sm83_dec_decode.sv
// ---------------------------------------------------------------------------
// sm83_dec_decode
// Field split and class decode of one opcode, with the CB page.
// ---------------------------------------------------------------------------
module sm83_dec_decode
  import sm83_dec_pkg::*;
(
  input  logic [7:0]  opcode,
  input  logic [7:0]  next_byte,
  output dec_result_t result
);

  logic [1:0] x, p, cx;
  logic [2:0] y, z, cy;
  logic       q;
  dec_result_t r;

  assign x  = opcode[7:6];
  assign y  = opcode[5:3];
  assign z  = opcode[2:0];
  assign p  = opcode[5:4];
  assign q  = opcode[3];
  assign cx = next_byte[7:6];
  assign cy = next_byte[5:3];

  always_comb begin
    r = '0;
    r.op_class = CLS_INVALID;
    unique case (x)
      2'd0: begin
        unique case (z)
          3'd0: begin
            unique case (y)
              3'd0:    r.op_class = CLS_NOP;
              3'd1:    r.op_class = CLS_LD_A16_SP;
              3'd2:    r.op_class = CLS_STOP;
              3'd3:    r.op_class = CLS_JR;
              default: begin
                r.op_class  = CLS_JR_CC;
                r.condition = y[1:0];
              end
            endcase
          end
          3'd1: begin
            r.op_class = q ? CLS_ADD_HL_RP : CLS_LD_RP_D16;
            r.reg_pair = p;
          end
          3'd2: begin
            unique case (p)
              2'd2:    r.op_class = q ? CLS_LDI_A_HL : CLS_LDI_HL_A;
              2'd3:    r.op_class = q ? CLS_LDD_A_HL : CLS_LDD_HL_A;
              default: begin
                r.op_class = q ? CLS_LD_A_RPIND : CLS_LD_RPIND_A;
                r.reg_pair = p;
              end
            endcase
          end
          3'd3: begin
            r.op_class = q ? CLS_DEC_RP : CLS_INC_RP;
            r.reg_pair = p;
          end
          3'd4: begin
            r.op_class = CLS_INC_R;
            r.dest_reg = y;
          end
          3'd5: begin
            r.op_class = CLS_DEC_R;
            r.dest_reg = y;
          end
          3'd6: begin
            r.op_class = CLS_LD_R_D8;
            r.dest_reg = y;
          end
          default: r.op_class = CLS_RLCA + {3'd0, y};
        endcase
      end
      2'd1: begin
        if (!(y == 3'd6 && z == 3'd6)) begin
          r.op_class = CLS_LD_R_R;
          r.dest_reg = y;
          r.src_reg  = z;
        end
      end
      2'd2: begin
        r.op_class   = CLS_ALU_A_R;
        r.dest_reg   = 3'd7;
        r.src_reg    = z;
        r.alu_select = y;
      end
      default: begin
        unique case (z)
          3'd0: begin
            if (!y[2]) begin
              r.op_class  = CLS_RET_CC;
              r.condition = y[1:0];
            end else begin
              r.op_class = CLS_LDH_A8_A + {4'd0, y[1:0]};
            end
          end
          3'd1: begin
            if (!q) begin
              r.op_class = CLS_POP;
              r.reg_pair = p;
            end else begin
              r.op_class = CLS_RET + {4'd0, p};
            end
          end
          3'd2: begin
            if (!y[2]) begin
              r.op_class  = CLS_JP_CC;
              r.condition = y[1:0];
            end else begin
              r.op_class = CLS_LD_C_A + {4'd0, y[1:0]};
            end
          end
          3'd3: begin
            unique case (y)
              3'd0: r.op_class = CLS_JP;
              3'd6: r.op_class = CLS_DI;
              3'd7: r.op_class = CLS_EI;
              3'd1: begin
                r.is_prefixed = 1'b1;
                r.dest_reg    = next_byte[2:0];
                if (cx == 2'd0) begin
                  r.op_class      = CLS_CB_ROT;
                  r.rotate_select = cy;
                end else begin
                  r.op_class  = CLS_CB_BIT + {4'd0, cx - 2'd1};
                  r.bit_index = cy;
                end
              end
              default: r.op_class = CLS_INVALID;
            endcase
          end
          3'd4: begin
            if (!y[2]) begin
              r.op_class  = CLS_CALL_CC;
              r.condition = y[1:0];
            end
          end
          3'd5: begin
            if (!q) begin
              r.op_class = CLS_PUSH;
              r.reg_pair = p;
            end else if (p == 2'd0) begin
              r.op_class = CLS_CALL;
            end
          end
          3'd6: begin
            r.op_class   = CLS_ALU_A_D8;
            r.dest_reg   = 3'd7;
            r.alu_select = y;
          end
          default: begin
            r.op_class       = CLS_RST;
            r.restart_target = {y, 3'd0};
          end
        endcase
      end
    endcase

    if (r.op_class == CLS_INVALID) begin
      result          = '0;
      result.op_class = CLS_INVALID;
    end else begin
      result           = r;
      result.imm_bytes = imm_of_class(r.op_class);
      result.valid_res = 1'b1;
    end
  end

endmodule

>>> test/sm83_opcode_decoder_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sm83_opcode_decoder_core_tb
// Stream-level test of the Game Boy CPU opcode decoder.
// ---------------------------------------------------------------------------
// Opcode/next-byte pairs go in on the slave stream. Each accepted pair is
// decoded by a local model and the expected record is queued. Every result
// taken from the master stream is compared field by field with the oldest
// queued record. The run covers the special opcodes, a sweep of both opcode
// pages, a long output stall that backs up the input, and a long random
// section. Both sides insert random idle cycles, with some stretches that
// run at full rate.

module sm83_opcode_decoder_core_tb;
  import sm83_dec_pkg::*;

  localparam int unsigned ClkPeriod    = 12;
  localparam int unsigned ResetCycles  = 5;
  localparam int unsigned DrainCycles  = 10;
  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned StallItems   = 40;
  localparam int unsigned StallCycles  = 80;
  localparam logic [7:0]  OpPrefixCb   = 8'hCB;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [InWidth-1:0]    s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OutWidth-1:0]   m_tdata;
  logic [UserWidth-1:0]  m_tuser;

  dec_result_t decode_q[$];
  int unsigned err_cnt;
  bit          full_rate;
  int unsigned hold_req;

  sm83_opcode_decoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #(ClkPeriod / 2) clk = ~clk;

  function automatic dec_result_t decode_opcode(input logic [7:0] op, input logic [7:0] nb);
    dec_result_t r;
    logic [1:0]  x;
    logic [1:0]  p;
    logic [2:0]  y;
    logic [2:0]  z;
    logic        q;
    x = op[7:6];
    y = op[5:3];
    z = op[2:0];
    p = op[5:4];
    q = op[3];
    r = '0;
    r.op_class = CLS_INVALID;
    case (x)
      2'd0: begin
        case (z)
          3'd0: begin
            if (y == 3'd0) r.op_class = CLS_NOP;
            else if (y == 3'd1) r.op_class = CLS_LD_A16_SP;
            else if (y == 3'd2) r.op_class = CLS_STOP;
            else if (y == 3'd3) r.op_class = CLS_JR;
            else begin
              r.op_class = CLS_JR_CC;
              r.condition = y[1:0];
            end
          end
          3'd1: begin
            r.op_class = q ? CLS_ADD_HL_RP : CLS_LD_RP_D16;
            r.reg_pair = p;
          end
          3'd2: begin
            if (p < 2'd2) begin
              r.op_class = q ? CLS_LD_A_RPIND : CLS_LD_RPIND_A;
              r.reg_pair = p;
            end else if (p == 2'd2) begin
              r.op_class = q ? CLS_LDI_A_HL : CLS_LDI_HL_A;
            end else begin
              r.op_class = q ? CLS_LDD_A_HL : CLS_LDD_HL_A;
            end
          end
          3'd3: begin
            r.op_class = q ? CLS_DEC_RP : CLS_INC_RP;
            r.reg_pair = p;
          end
          3'd4: begin
            r.op_class = CLS_INC_R;
            r.dest_reg = y;
          end
          3'd5: begin
            r.op_class = CLS_DEC_R;
            r.dest_reg = y;
          end
          3'd6: begin
            r.op_class = CLS_LD_R_D8;
            r.dest_reg = y;
          end
          default: begin
            r.op_class = CLS_RLCA + op_class_t'(y);
          end
        endcase
      end
      2'd1: begin
        if (!(y == 3'd6 && z == 3'd6)) begin
          r.op_class = CLS_LD_R_R;
          r.dest_reg = y;
          r.src_reg  = z;
        end
      end
      2'd2: begin
        r.op_class   = CLS_ALU_A_R;
        r.dest_reg   = 3'd7;
        r.src_reg    = z;
        r.alu_select = y;
      end
      default: begin
        case (z)
          3'd0: begin
            if (!y[2]) begin
              r.op_class  = CLS_RET_CC;
              r.condition = y[1:0];
            end else begin
              r.op_class = CLS_LDH_A8_A + op_class_t'(y[1:0]);
            end
          end
          3'd1: begin
            if (!q) begin
              r.op_class = CLS_POP;
              r.reg_pair = p;
            end else begin
              r.op_class = CLS_RET + op_class_t'(p);
            end
          end
          3'd2: begin
            if (!y[2]) begin
              r.op_class  = CLS_JP_CC;
              r.condition = y[1:0];
            end else begin
              r.op_class = CLS_LD_C_A + op_class_t'(y[1:0]);
            end
          end
          3'd3: begin
            if (y == 3'd0) r.op_class = CLS_JP;
            else if (y == 3'd6) r.op_class = CLS_DI;
            else if (y == 3'd7) r.op_class = CLS_EI;
            else if (y == 3'd1) begin
              r.is_prefixed = 1'b1;
              r.dest_reg    = nb[2:0];
              if (nb[7:6] == 2'd0) begin
                r.op_class      = CLS_CB_ROT;
                r.rotate_select = nb[5:3];
              end else begin
                r.op_class  = CLS_CB_BIT + op_class_t'(nb[7:6] - 2'd1);
                r.bit_index = nb[5:3];
              end
            end
          end
          3'd4: begin
            if (!y[2]) begin
              r.op_class  = CLS_CALL_CC;
              r.condition = y[1:0];
            end
          end
          3'd5: begin
            if (!q) begin
              r.op_class = CLS_PUSH;
              r.reg_pair = p;
            end else if (p == 2'd0) begin
              r.op_class = CLS_CALL;
            end
          end
          3'd6: begin
            r.op_class   = CLS_ALU_A_D8;
            r.dest_reg   = 3'd7;
            r.alu_select = y;
          end
          default: begin
            r.op_class       = CLS_RST;
            r.restart_target = {y, 3'b000};
          end
        endcase
      end
    endcase

    if (r.op_class == CLS_INVALID) begin
      r = '0;
      r.op_class = CLS_INVALID;
      return r;
    end
    case (r.op_class)
      CLS_LD_A16_SP, CLS_LD_RP_D16, CLS_LD_A16_A, CLS_LD_A_A16,
      CLS_JP_CC, CLS_JP, CLS_CALL_CC, CLS_CALL: r.imm_bytes = 2'd2;
      CLS_STOP, CLS_JR, CLS_JR_CC, CLS_LD_R_D8, CLS_LDH_A8_A, CLS_ADD_SP_E8,
      CLS_LDH_A_A8, CLS_LDHL_SP_E8, CLS_ALU_A_D8: r.imm_bytes = 2'd1;
      default: r.imm_bytes = 2'd0;
    endcase
    r.valid_res = 1'b1;
    return r;
  endfunction

  // Offer one pair after a random gap and hold it until the transfer.
  task automatic send_pair(input logic [7:0] op, input logic [7:0] nb);
    int unsigned gap;
    gap = full_rate ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {nb, op};
    do @(posedge clk); while (!s_tready);
    decode_q.push_back(decode_opcode(op, nb));
  endtask

  task automatic compare_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  task automatic check_result(input logic [OutWidth-1:0] data,
                              input logic [UserWidth-1:0] user);
    dec_result_t want;
    if (decode_q.size() == 0) begin
      $display("%0t: unexpected result, actual data %h user %b", $time, data, user);
      err_cnt++;
      return;
    end
    want = decode_q.pop_front();
    compare_field("op_class", 32'(want.op_class), 32'(data[5:0]));
    compare_field("dest_reg", 32'(want.dest_reg), 32'(data[8:6]));
    compare_field("src_reg", 32'(want.src_reg), 32'(data[11:9]));
    compare_field("reg_pair", 32'(want.reg_pair), 32'(data[13:12]));
    compare_field("condition", 32'(want.condition), 32'(data[15:14]));
    compare_field("alu_select", 32'(want.alu_select), 32'(data[18:16]));
    compare_field("rotate_select", 32'(want.rotate_select), 32'(data[21:19]));
    compare_field("bit_index", 32'(want.bit_index), 32'(data[24:22]));
    compare_field("restart_target", 32'(want.restart_target), 32'(data[30:25]));
    compare_field("imm_bytes", 32'(want.imm_bytes), 32'(data[32:31]));
    compare_field("tdata padding", 0, 32'(data[OutWidth-1:33]));
    compare_field("is_prefixed", 32'(want.is_prefixed), 32'(user[0]));
    compare_field("valid_res", 32'(want.valid_res), 32'(user[1]));
  endtask

  // Result side: random back-pressure, one long hold-off on request.
  initial begin
    int unsigned stall;
    m_tready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = full_rate ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result(m_tdata, m_tuser);
    end
  end

  task automatic test_special_opcodes();
    logic [7:0] removed[11];
    removed = '{8'hD3, 8'hDB, 8'hDD, 8'hE3, 8'hE4, 8'hEB,
                8'hEC, 8'hED, 8'hF4, 8'hFC, 8'hFD};
    send_pair(8'h00, 8'h00);
    send_pair(8'hFF, 8'hFF);
    send_pair(8'h76, 8'($urandom_range(0, 255)));
    send_pair(8'hF2, 8'($urandom_range(0, 255)));
    send_pair(8'h10, 8'($urandom_range(0, 255)));
    send_pair(8'hE8, 8'($urandom_range(0, 255)));
    send_pair(8'hF8, 8'($urandom_range(0, 255)));
    foreach (removed[i]) send_pair(removed[i], 8'($urandom_range(0, 255)));
    send_pair(OpPrefixCb, 8'h00);
    send_pair(OpPrefixCb, 8'h36);
    send_pair(OpPrefixCb, 8'h40);
    send_pair(OpPrefixCb, 8'h80);
    send_pair(OpPrefixCb, 8'hC0);
    send_pair(OpPrefixCb, 8'hFF);
  endtask

  task automatic test_opcode_sweep();
    for (int i = 0; i < 256; i++) send_pair(8'(i), 8'($urandom_range(0, 255)));
    for (int i = 0; i < 256; i++) send_pair(OpPrefixCb, 8'(i));
  endtask

  // Hold the output off while the input runs at full rate.
  task automatic test_output_stall();
    full_rate = 1'b1;
    hold_req  = StallCycles;
    for (int i = 0; i < StallItems; i++) begin
      send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    full_rate = 1'b0;
  endtask

  task automatic test_random_stream();
    logic [7:0] op;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) full_rate = ($urandom_range(0, 3) == 0);
      op = ($urandom_range(0, 3) == 0) ? OpPrefixCb : 8'($urandom_range(0, 255));
      send_pair(op, 8'($urandom_range(0, 255)));
    end
    full_rate = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    err_cnt   = 0;
    full_rate = 1'b0;
    hold_req  = 0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_special_opcodes();
    test_opcode_sweep();
    test_output_stall();
    test_random_stream();

    s_tvalid <= 1'b0;
    while (decode_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("sm83_opcode_decoder_core test passed");
    end else begin
      $display("sm83_opcode_decoder_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sm83_opcode_decoder_core test failed");
    $finish;
  end

endmodule
